@@ hdl/alist_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// alist_pkg: shared types and constants for the array list block
// Sizes, command and status codes, and the request record that moves from
// the front end through the queue to the execution back end.
// ----------------------------------------------------------------------------
package alist_pkg;

    localparam int DEPTH       = 64;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int CMD_W       = 3;
    localparam int POS_W       = 6;
    localparam int STAT_W      = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 3'd0,
        CMD_APPEND = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_DELETE = 3'd3,
        CMD_SEARCH = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_APPEND,
        OP_INSERT,
        OP_DELETE,
        OP_SEARCH,
        OP_NOP
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_BADPOS   = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_MATCH    = 3'd4
    } status_t;

    typedef struct packed {
        op_t                      op;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } req_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             busy;
    } back_info_t;

endpackage

`default_nettype wire

@@ hdl/array_list_insert_delete_search.sv @@
`default_nettype none
// Clear, append, unknown and rejected commands go straight from accept to report;
//   insert and delete first shift the entries from position on, then report.
// Search: matches at most one per cycle, unless the output stalls; last on final item.
// Throughput: one item at a time in the back end; shifts and scans move one entry per
//   cycle through the single read and write port of the RAM; a scan can wait on out_stall.
// Reset: list count goes to zero at once; entry RAM is not cleared, no clearing pass.
// ----------------------------------------------------------------------------
// array_list_insert_delete_search: ordered list with insert, delete, search
// Front end registers and decodes items, a two-entry queue decouples it
// from the back end, which runs each command against a 64 x 32 entry RAM.
// ----------------------------------------------------------------------------
module array_list_insert_delete_search (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [alist_pkg::CMD_W-1:0]         command,
    input  wire logic signed [alist_pkg::DATA_W-1:0] value,
    input  wire logic [alist_pkg::POS_W-1:0]         position,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [alist_pkg::STAT_W-1:0]             status,
    output logic [alist_pkg::POS_W-1:0]              found_position,
    output logic [alist_pkg::CNT_W-1:0]              count,
    output logic                                     last
);

    // front end to queue
    logic                                push;
    alist_pkg::req_t                     push_req;
    logic                                q_full;
    // queue to back end
    logic                                q_valid;
    alist_pkg::req_t                     q_head;
    logic                                pop;
    // back end to entry RAM
    logic                                ram_we;
    logic [alist_pkg::ADDR_W-1:0]        ram_waddr;
    logic [alist_pkg::DATA_W-1:0]        ram_wdata;
    logic                                ram_re;
    logic [alist_pkg::ADDR_W-1:0]        ram_raddr;
    logic [alist_pkg::DATA_W-1:0]        ram_rdata;
    alist_pkg::back_info_t               info;

    // Accept and decode; hold the item while the queue is full.
    alist_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .command  (command),
        .value    (value),
        .position (position),
        .push     (push),
        .push_req (push_req),
        .q_full   (q_full)
    );

    // Buffer decoded requests so the front keeps taking items during a long shift.
    alist_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_req  (push_req),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    // Entry store: one write and one registered read per cycle.
    alist_ram #(
        .WIDTH (alist_pkg::DATA_W),
        .DEPTH (alist_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Execute commands and drive the result register.
    alist_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_req          (q_head),
        .pop            (pop),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_re         (ram_re),
        .ram_raddr      (ram_raddr),
        .ram_rdata      (ram_rdata),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .found_position (found_position),
        .count          (count),
        .last           (last),
        .info           (info)
    );

    // The list never holds more than its depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        info.count <= alist_pkg::CNT_W'(alist_pkg::DEPTH))
        else $error("list count above depth");

    // Only search matches may come without last.
    a_nonlast_match: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> (status == alist_pkg::ST_MATCH))
        else $error("non-final item that is not a match");

    // A match position always lies inside the reported list.
    a_match_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == alist_pkg::ST_MATCH)
            |-> (alist_pkg::CNT_W'(found_position) < count))
        else $error("match position beyond count");

    // A queue pop only happens while the back end is idle.
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> info.busy || $past(q_head.op) == alist_pkg::OP_NOP
            || $past(q_head.op) == alist_pkg::OP_CLEAR
            || $past(q_head.op) == alist_pkg::OP_APPEND
            || $past(q_head.op) == alist_pkg::OP_INSERT
            || $past(q_head.op) == alist_pkg::OP_DELETE
            || $past(q_head.op) == alist_pkg::OP_SEARCH)
        else $error("request popped without being started");

endmodule

`default_nettype wire

@@ hdl/alist_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// alist_ram: generic simple dual-port RAM
// One write port and one read port, read data registered on read enable.
// ----------------------------------------------------------------------------
module alist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hdl/alist_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// alist_front: input stage
// Register each accepted item, decode its command into an operation and
// hand it to the queue.
// ----------------------------------------------------------------------------
module alist_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [alist_pkg::CMD_W-1:0]       command,
    input  wire logic signed [alist_pkg::DATA_W-1:0] value,
    input  wire logic [alist_pkg::POS_W-1:0]       position,
    output logic                                   push,
    output alist_pkg::req_t                        push_req,
    input  wire logic                              q_full
);

    logic            valid_reg;
    logic            valid_next;
    alist_pkg::req_t req_reg;
    alist_pkg::req_t req_next;
    alist_pkg::op_t  op_dec;
    logic            accept;

    // unknown codes become a no-op that still reports
    always_comb
    begin
        unique case (command)
            alist_pkg::CMD_CLEAR:  op_dec = alist_pkg::OP_CLEAR;
            alist_pkg::CMD_APPEND: op_dec = alist_pkg::OP_APPEND;
            alist_pkg::CMD_INSERT: op_dec = alist_pkg::OP_INSERT;
            alist_pkg::CMD_DELETE: op_dec = alist_pkg::OP_DELETE;
            alist_pkg::CMD_SEARCH: op_dec = alist_pkg::OP_SEARCH;
            default:               op_dec = alist_pkg::OP_NOP;
        endcase
    end

    assign in_stall = valid_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign push     = valid_reg && !q_full;
    assign push_req = req_reg;

    always_comb
    begin
        valid_next = valid_reg;
        req_next   = req_reg;
        if (accept)
        begin
            valid_next        = 1'b1;
            req_next.op       = op_dec;
            req_next.value    = value;
            req_next.position = position;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            req_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            req_reg   <= req_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/alist_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// alist_queue: short request queue
// Decouple the front end from the back end; first in, first out.
// ----------------------------------------------------------------------------
module alist_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire alist_pkg::req_t push_req,
    output logic                 full,
    input  wire logic            pop,
    output logic                 not_empty,
    output alist_pkg::req_t      head
);

    alist_pkg::req_t                 slot_reg [alist_pkg::QUEUE_DEPTH];
    logic [alist_pkg::QPTR_W-1:0]    wptr_reg;
    logic [alist_pkg::QPTR_W-1:0]    wptr_next;
    logic [alist_pkg::QPTR_W-1:0]    rptr_reg;
    logic [alist_pkg::QPTR_W-1:0]    rptr_next;
    logic [alist_pkg::QCNT_W-1:0]    fill_reg;
    logic [alist_pkg::QCNT_W-1:0]    fill_next;
    logic                            do_push;
    logic                            do_pop;

    assign full      = (fill_reg == alist_pkg::QCNT_W'(alist_pkg::QUEUE_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign head      = slot_reg[rptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        fill_next = fill_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == alist_pkg::QPTR_W'(alist_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == alist_pkg::QPTR_W'(alist_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= push_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/alist_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// alist_back: execution sequencer
// Run each request against the entry RAM: shift for insert and delete,
// scan for search, and drive the registered result port.
// ----------------------------------------------------------------------------
module alist_back (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               q_valid,
    input  wire alist_pkg::req_t                    q_req,
    output logic                                    pop,
    output logic                                    ram_we,
    output logic [alist_pkg::ADDR_W-1:0]            ram_waddr,
    output logic [alist_pkg::DATA_W-1:0]            ram_wdata,
    output logic                                    ram_re,
    output logic [alist_pkg::ADDR_W-1:0]            ram_raddr,
    input  wire logic [alist_pkg::DATA_W-1:0]       ram_rdata,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [alist_pkg::STAT_W-1:0]            status,
    output logic [alist_pkg::POS_W-1:0]             found_position,
    output logic [alist_pkg::CNT_W-1:0]             count,
    output logic                                    last,
    output alist_pkg::back_info_t                   info
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_DEL,
        S_SRCH,
        S_REPORT
    } state_t;

    localparam int CW = alist_pkg::CNT_W;
    localparam int AW = alist_pkg::ADDR_W;

    state_t                          state_reg,      state_next;
    logic [CW-1:0]                   count_reg,      count_next;
    logic [CW-1:0]                   ptr_reg,        ptr_next;
    logic [CW-1:0]                   pos_reg,        pos_next;
    logic [alist_pkg::DATA_W-1:0]    val_reg,        val_next;
    logic                            pend_wr_reg,    pend_wr_next;
    logic [AW-1:0]                   wa_reg,         wa_next;
    logic                            hit_valid_reg,  hit_valid_next;
    logic [AW-1:0]                   hit_pos_reg,    hit_pos_next;
    alist_pkg::status_t              rstat_reg,      rstat_next;
    logic                            ovalid_reg,     ovalid_next;
    alist_pkg::status_t              ostat_reg,      ostat_next;
    logic [AW-1:0]                   ofpos_reg,      ofpos_next;
    logic [CW-1:0]                   ocount_reg,     ocount_next;
    logic                            olast_reg,      olast_next;

    logic                            out_free;
    logic                            hit;
    logic                            block;
    logic [CW-1:0]                   q_pos;

    assign out_free = !ovalid_reg || !out_stall;
    assign q_pos    = CW'(q_req.position);
    // pend_wr doubles as "read data holds entry wa" during the scan
    assign hit      = pend_wr_reg && (ram_rdata == val_reg);
    assign block    = hit && hit_valid_reg && !out_free;
    assign pop      = (state_reg == S_IDLE) && q_valid;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        pend_wr_next   = pend_wr_reg;
        wa_next        = wa_reg;
        hit_valid_next = hit_valid_reg;
        hit_pos_next   = hit_pos_reg;
        rstat_next     = rstat_reg;
        ovalid_next    = ovalid_reg && out_stall;
        ostat_next     = ostat_reg;
        ofpos_next     = ofpos_reg;
        ocount_next    = ocount_reg;
        olast_next     = olast_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    val_next     = q_req.value;
                    pos_next     = q_pos;
                    pend_wr_next = 1'b0;
                    rstat_next   = alist_pkg::ST_OK;
                    state_next   = S_REPORT;
                    unique case (q_req.op)
                        alist_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        alist_pkg::OP_APPEND:
                        begin
                            if (count_reg >= CW'(alist_pkg::DEPTH))
                            begin
                                rstat_next = alist_pkg::ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = AW'(count_reg);
                                ram_wdata  = q_req.value;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        alist_pkg::OP_INSERT:
                        begin
                            if (count_reg >= CW'(alist_pkg::DEPTH))
                            begin
                                rstat_next = alist_pkg::ST_FULL;
                            end
                            else if (q_pos > count_reg)
                            begin
                                rstat_next = alist_pkg::ST_BADPOS;
                            end
                            else
                            begin
                                ptr_next   = count_reg;
                                state_next = S_INS;
                            end
                        end
                        alist_pkg::OP_DELETE:
                        begin
                            if (q_pos >= count_reg)
                            begin
                                rstat_next = alist_pkg::ST_BADPOS;
                            end
                            else
                            begin
                                ptr_next   = q_pos + 1'b1;
                                state_next = S_DEL;
                            end
                        end
                        alist_pkg::OP_SEARCH:
                        begin
                            ptr_next       = '0;
                            hit_valid_next = 1'b0;
                            state_next     = S_SRCH;
                        end
                        default:
                        begin
                            rstat_next = alist_pkg::ST_OK;
                        end
                    endcase
                end
            end

            S_INS:
            begin
                // move entry wa up by one, one entry per cycle, top first
                if (pend_wr_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = wa_reg + 1'b1;
                    ram_wdata = ram_rdata;
                end
                if (ptr_reg > pos_reg)
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = AW'(ptr_reg - 1'b1);
                    wa_next      = AW'(ptr_reg - 1'b1);
                    pend_wr_next = 1'b1;
                    ptr_next     = ptr_reg - 1'b1;
                end
                else
                begin
                    pend_wr_next = 1'b0;
                    if (!pend_wr_reg)
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = AW'(pos_reg);
                        ram_wdata  = val_reg;
                        count_next = count_reg + 1'b1;
                        state_next = S_REPORT;
                    end
                end
            end

            S_DEL:
            begin
                // move entry wa down by one, bottom first
                if (pend_wr_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = wa_reg - 1'b1;
                    ram_wdata = ram_rdata;
                end
                if (ptr_reg < count_reg)
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = AW'(ptr_reg);
                    wa_next      = AW'(ptr_reg);
                    pend_wr_next = 1'b1;
                    ptr_next     = ptr_reg + 1'b1;
                end
                else
                begin
                    pend_wr_next = 1'b0;
                    if (!pend_wr_reg)
                    begin
                        count_next = count_reg - 1'b1;
                        state_next = S_REPORT;
                    end
                end
            end

            S_SRCH:
            begin
                // hold back the newest match so the final one can carry last
                if (!block)
                begin
                    if (hit)
                    begin
                        if (hit_valid_reg)
                        begin
                            ovalid_next = 1'b1;
                            ostat_next  = alist_pkg::ST_MATCH;
                            ofpos_next  = hit_pos_reg;
                            ocount_next = count_reg;
                            olast_next  = 1'b0;
                        end
                        hit_valid_next = 1'b1;
                        hit_pos_next   = wa_reg;
                    end
                    if (ptr_reg < count_reg)
                    begin
                        ram_re       = 1'b1;
                        ram_raddr    = AW'(ptr_reg);
                        wa_next      = AW'(ptr_reg);
                        pend_wr_next = 1'b1;
                        ptr_next     = ptr_reg + 1'b1;
                    end
                    else
                    begin
                        pend_wr_next = 1'b0;
                    end
                end
                if (!pend_wr_reg && ptr_reg == count_reg && out_free)
                begin
                    ovalid_next = 1'b1;
                    ostat_next  = hit_valid_reg ? alist_pkg::ST_MATCH
                                                : alist_pkg::ST_NOTFOUND;
                    ofpos_next  = hit_valid_reg ? hit_pos_reg : '0;
                    ocount_next = count_reg;
                    olast_next  = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            S_REPORT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ostat_next  = rstat_reg;
                    ofpos_next  = '0;
                    ocount_next = count_reg;
                    olast_next  = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ptr_reg       <= '0;
            pos_reg       <= '0;
            val_reg       <= '0;
            pend_wr_reg   <= 1'b0;
            wa_reg        <= '0;
            hit_valid_reg <= 1'b0;
            hit_pos_reg   <= '0;
            rstat_reg     <= alist_pkg::ST_OK;
            ovalid_reg    <= 1'b0;
            ostat_reg     <= alist_pkg::ST_OK;
            ofpos_reg     <= '0;
            ocount_reg    <= '0;
            olast_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            pos_reg       <= pos_next;
            val_reg       <= val_next;
            pend_wr_reg   <= pend_wr_next;
            wa_reg        <= wa_next;
            hit_valid_reg <= hit_valid_next;
            hit_pos_reg   <= hit_pos_next;
            rstat_reg     <= rstat_next;
            ovalid_reg    <= ovalid_next;
            ostat_reg     <= ostat_next;
            ofpos_reg     <= ofpos_next;
            ocount_reg    <= ocount_next;
            olast_reg     <= olast_next;
        end
    end

    assign out_valid      = ovalid_reg;
    assign status         = ostat_reg;
    assign found_position = alist_pkg::POS_W'(ofpos_reg);
    assign count          = ocount_reg;
    assign last           = olast_reg;
    assign info.count     = count_reg;
    assign info.busy      = (state_reg != S_IDLE);

endmodule

`default_nettype wire
